@@ rtl/process_table_round_robin_scheduler_macros.svh @@
// Assertion macros shared by the process table scheduler RTL.
`ifndef PROCESS_TABLE_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define PROCESS_TABLE_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define PRRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("process table scheduler assertion failed");
// The condition must never be true at a clock edge outside reset.
`define PRRS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("process table scheduler assertion failed");
`else
`define PRRS_ASSERT(lbl, clk, rst_n, prop)
`define PRRS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/prrs_pkg.sv @@
// Types, constants and helper functions of the process table scheduler.
`default_nettype none
package prrs_pkg;

    localparam int PID_W                 = 8;
    localparam int PID_RANGE             = 1 << PID_W;
    localparam int TABLE_ENTRIES_DEFAULT = 256;

    // The ready search works on groups of GRP_W entries; the group vector
    // has the same width, so one encoder function serves both levels.
    localparam int GRP_W  = 16;
    localparam int GRP_N  = PID_RANGE / GRP_W;
    localparam int GRP_IW = $clog2(GRP_W);

    typedef enum logic [1:0] {
        OP_CREATE    = 2'd0,
        OP_TERMINATE = 2'd1,
        OP_SCHEDULE  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        PS_NEW        = 3'd0,
        PS_READY      = 3'd1,
        PS_RUNNING    = 3'd2,
        PS_WAITING    = 3'd3,
        PS_TERMINATED = 3'd4
    } pstate_t;

    typedef enum logic [1:0] {
        RS_DONE     = 2'd0,
        RS_NOCHANGE = 2'd1,
        RS_NONE     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_SEARCH,
        ST_DEMOTE,
        ST_PROMOTE,
        ST_FINISH
    } fsm_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [PID_W-1:0] pid;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [PID_W-1:0] pid_out;
        logic [2:0]       state_out;
    } rsp_t;

    typedef struct packed {
        logic           go;
        logic [PID_W:0] origin;
    } pick_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [PID_W-1:0] idx;
    } pick_res_t;

    // Index of the lowest set bit, zero when none is set.
    function automatic logic [GRP_IW-1:0] lowest_set(input logic [GRP_W-1:0] v);
        logic [GRP_IW-1:0] r;
        r = '0;
        for (int i = GRP_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = GRP_IW'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/prrs_pick.sv @@
// Rotating priority search of the ready mask, in three registered stages.
`default_nettype none
module prrs_pick #(
    parameter int USED = prrs_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prrs_pkg::pick_req_t pick_req,
    input  logic [USED-1:0]     ready,
    output prrs_pkg::pick_res_t pick_res
);
    import prrs_pkg::*;

    logic [PID_RANGE-1:0] ready_pad;
    logic [PID_RANGE-1:0] masked;
    logic [PID_W:0]       origin_reg;
    logic                 s1_reg;
    logic                 s2_reg;
    logic                 s3_reg;
    logic                 done_reg;
    logic [GRP_N-1:0]     hi_any_next;
    logic [GRP_N-1:0]     all_any_next;
    logic [GRP_N-1:0]     hi_any_reg;
    logic [GRP_N-1:0]     all_any_reg;
    logic                 use_hi_next;
    logic                 use_hi_reg;
    logic [GRP_IW-1:0]    grp_next;
    logic [GRP_IW-1:0]    grp_reg;
    logic                 found_next;
    logic                 found_reg;
    logic [GRP_W-1:0]     grp_bits;
    logic [PID_W-1:0]     idx_next;
    logic [PID_W-1:0]     idx_reg;

    assign ready_pad = PID_RANGE'(ready);

    // Entries at or after the search origin take precedence over the rest.
    always_comb
    begin
        for (int i = 0; i < PID_RANGE; i++)
        begin
            masked[i] = ready_pad[i] & ((PID_W + 1)'(i) >= origin_reg);
        end
        for (int g = 0; g < GRP_N; g++)
        begin
            hi_any_next[g]  = |masked[g*GRP_W +: GRP_W];
            all_any_next[g] = |ready_pad[g*GRP_W +: GRP_W];
        end
    end

    always_comb
    begin
        use_hi_next = |hi_any_reg;
        found_next  = |all_any_reg;
        grp_next    = lowest_set(use_hi_next ? hi_any_reg : all_any_reg);
    end

    always_comb
    begin
        grp_bits = use_hi_reg ? masked[grp_reg*GRP_W +: GRP_W]
                              : ready_pad[grp_reg*GRP_W +: GRP_W];
        idx_next = {grp_reg, lowest_set(grp_bits)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            s3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= pick_req.go;
            s2_reg   <= s1_reg;
            s3_reg   <= s2_reg;
            done_reg <= s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pick_req.go)
        begin
            origin_reg <= pick_req.origin;
        end
        if (s1_reg)
        begin
            hi_any_reg  <= hi_any_next;
            all_any_reg <= all_any_next;
        end
        if (s2_reg)
        begin
            use_hi_reg <= use_hi_next;
            grp_reg    <= grp_next;
            found_reg  <= found_next;
        end
        if (s3_reg)
        begin
            idx_reg <= idx_next;
        end
    end

    assign pick_res.done  = done_reg;
    assign pick_res.found = found_reg;
    assign pick_res.idx   = idx_reg;

endmodule
`default_nettype wire

@@ rtl/process_table_round_robin_scheduler.sv @@
// Top level of the round-robin process table scheduler.
// One request is worked on at a time; the response register then frees the input side.
// Create, unused opcodes and terminates of pids outside the table go straight to the response;
// terminate reads and then writes the table; schedule runs three search stages and two table
// writes (none if nothing is ready). Responses that stall hold back the next request.
// Reset is asynchronous and active low; the table reads as all new at once, no sweep.
`default_nettype none
`include "process_table_round_robin_scheduler_macros.svh"
module process_table_round_robin_scheduler #(
    parameter int TABLE_ENTRIES = prrs_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  prrs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output prrs_pkg::rsp_t rsp
);
    import prrs_pkg::*;

    // Entries at or above the pid range can never be addressed, so they can
    // never become ready; only the addressable part of the table is stored.
    localparam int USED  = (TABLE_ENTRIES < PID_RANGE) ? TABLE_ENTRIES : PID_RANGE;
    localparam int IDX_W = $clog2(USED);

    fsm_t             fsm_reg;
    fsm_t             fsm_next;
    logic [PID_W-1:0] pid_reg;
    logic [PID_W-1:0] pid_next;
    logic [PID_W-1:0] rr_reg;
    logic [PID_W-1:0] rr_next;
    logic [PID_W-1:0] run_reg;
    logic [PID_W-1:0] run_next;
    logic             run_valid_reg;
    logic             run_valid_next;
    rsp_t             res_reg;
    rsp_t             res_next;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg;
    logic             load_rsp;
    logic             accept;
    logic             in_range;

    // State table: a one-port-write, one-port-read memory with a registered
    // read. A written bit per entry makes an untouched entry read as new.
    pstate_t          mem [USED];
    logic [USED-1:0]  written_reg;
    logic [USED-1:0]  ready_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    pstate_t          mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    pstate_t          rd_data_reg;
    logic             rd_valid_reg;
    pstate_t          rd_state;

    pick_req_t        pick_req;
    pick_res_t        pick_res;

    function automatic rsp_t make_rsp(input status_t s, input logic [PID_W-1:0] p,
                                      input pstate_t st);
        rsp_t r;
        r.status    = s;
        r.pid_out   = p;
        r.state_out = st;
        return r;
    endfunction

    // Requests are taken only between operations; a finished response may
    // still sit in the output register while the next request is taken.
    assign req_stall = (fsm_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign in_range  = (32'(req.pid) < TABLE_ENTRIES);
    assign rd_state  = rd_valid_reg ? rd_data_reg : PS_NEW;

    // The ready mask mirrors which table entries hold the ready state and
    // feeds the rotating search.
    prrs_pick #(
        .USED (USED)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .pick_req (pick_req),
        .ready    (ready_reg),
        .pick_res (pick_res)
    );

    // Next state.
    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        OP_CREATE:    fsm_next = ST_FINISH;
                        OP_TERMINATE: fsm_next = in_range ? ST_TERM : ST_FINISH;
                        OP_SCHEDULE:  fsm_next = ST_SEARCH;
                        default:      fsm_next = ST_FINISH;
                    endcase
                end
            end
            ST_TERM:
            begin
                fsm_next = ST_FINISH;
            end
            ST_SEARCH:
            begin
                if (pick_res.done)
                begin
                    fsm_next = pick_res.found ? ST_DEMOTE : ST_FINISH;
                end
            end
            ST_DEMOTE:
            begin
                fsm_next = ST_PROMOTE;
            end
            ST_PROMOTE:
            begin
                fsm_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    fsm_next = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    // Memory accesses, search start and result of each step.
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = req.pid[IDX_W-1:0];
        mem_wdata       = PS_NEW;
        mem_re          = 1'b0;
        mem_raddr       = req.pid[IDX_W-1:0];
        pick_req.go     = 1'b0;
        pick_req.origin = (PID_W + 1)'(rr_reg) + (PID_W + 1)'(1);
        pid_next        = pid_reg;
        rr_next         = rr_reg;
        run_next        = run_reg;
        run_valid_next  = run_valid_reg;
        res_next        = res_reg;
        load_rsp        = 1'b0;
        case (fsm_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pid_next = req.pid;
                    case (req.opcode)
                        OP_CREATE:
                        begin
                            // Creation makes any entry ready, running or
                            // terminated ones included.
                            if (in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = PS_READY;
                                res_next  = make_rsp(RS_DONE, req.pid, PS_READY);
                            end
                            else
                            begin
                                res_next = make_rsp(RS_NOCHANGE, req.pid, PS_NEW);
                            end
                        end
                        OP_TERMINATE:
                        begin
                            if (in_range)
                            begin
                                mem_re = 1'b1;
                            end
                            else
                            begin
                                res_next = make_rsp(RS_NOCHANGE, req.pid, PS_NEW);
                            end
                        end
                        OP_SCHEDULE:
                        begin
                            // The running entry is read now so that its state
                            // is at hand when the search has finished.
                            mem_re      = 1'b1;
                            mem_raddr   = run_reg[IDX_W-1:0];
                            pick_req.go = 1'b1;
                        end
                        default:
                        begin
                            res_next = make_rsp(RS_NOCHANGE, '0, PS_NEW);
                        end
                    endcase
                end
            end
            ST_TERM:
            begin
                if (rd_state == PS_TERMINATED)
                begin
                    res_next = make_rsp(RS_NOCHANGE, pid_reg, PS_TERMINATED);
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pid_reg[IDX_W-1:0];
                    mem_wdata = PS_TERMINATED;
                    res_next  = make_rsp(RS_DONE, pid_reg, PS_TERMINATED);
                end
            end
            ST_SEARCH:
            begin
                if (pick_res.done && !pick_res.found)
                begin
                    res_next = make_rsp(RS_NONE, '0, PS_NEW);
                end
            end
            ST_DEMOTE:
            begin
                // The previous pick goes back to ready only if it still runs;
                // a terminated or re-created entry keeps its state.
                if (run_valid_reg && rd_state == PS_RUNNING)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = run_reg[IDX_W-1:0];
                    mem_wdata = PS_READY;
                end
            end
            ST_PROMOTE:
            begin
                mem_we         = 1'b1;
                mem_waddr      = pick_res.idx[IDX_W-1:0];
                mem_wdata      = PS_RUNNING;
                rr_next        = pick_res.idx;
                run_next       = pick_res.idx;
                run_valid_next = 1'b1;
                res_next       = make_rsp(RS_DONE, pick_res.idx, PS_RUNNING);
            end
            ST_FINISH:
            begin
                load_rsp = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                load_rsp = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            rr_reg        <= '0;
            run_reg       <= '0;
            run_valid_reg <= 1'b0;
            written_reg   <= '0;
            ready_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            rr_reg        <= rr_next;
            run_reg       <= run_next;
            run_valid_reg <= run_valid_next;
            if (mem_we)
            begin
                written_reg[mem_waddr] <= 1'b1;
                ready_reg[mem_waddr]   <= (mem_wdata == PS_READY);
            end
            if (mem_re)
            begin
                rd_valid_reg <= written_reg[mem_raddr];
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg <= pid_next;
        res_reg <= res_next;
        if (load_rsp)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A successful search must point at an entry that is ready.
    `PRRS_ASSERT(a_pick_is_ready, clk, rst_n,
        (pick_res.done && pick_res.found) |-> ready_reg[pick_res.idx[IDX_W-1:0]])
    // The search only reports while the control waits for it.
    `PRRS_NEVER(a_pick_when_searching, clk, rst_n,
        pick_res.done && (fsm_reg != ST_SEARCH))
    // Once something has been picked, the pointer and running entry agree.
    `PRRS_ASSERT(a_rr_tracks_running, clk, rst_n, run_valid_reg |-> (rr_reg == run_reg))
    // A response is never loaded over one that is still held by the consumer.
    `PRRS_NEVER(a_no_overwrite, clk, rst_n, load_rsp && rsp_valid_reg && rsp_stall)

endmodule
`default_nettype wire

@@ dv/process_table_round_robin_scheduler_test.sv @@
// Self-checking testbench for the round-robin process table scheduler.
`default_nettype none
module process_table_round_robin_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prrs_pkg::*;

    // The opcode that the block must answer with "no change" and otherwise ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int TABLE_SIZE   = TABLE_ENTRIES_DEFAULT;
    localparam int RANDOM_ITEMS = 750;
    // The slowest correct run ends well before this limit, even with the
    // longest sender gaps, the longest receiver stalls and the slowest schedules.
    localparam int CYCLE_LIMIT  = 400000;
    // Schedule is the slowest request; this is a comfortable margin.
    localparam int DRAIN_CYCLES = 32;
    // The receiver's one deliberate long hold-off, in cycles.
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int HOLD_OFF_AFTER  = 150;

    // One line of the directed stimulus. Where known is set, the response is typed
    // in by hand; otherwise the predictor supplies it.
    typedef struct packed {
        logic [1:0]       opcode;
        logic [PID_W-1:0] pid;
        logic             known;
        rsp_t             want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Predictor state: a private copy of the process table and the pointers.
    pstate_t    proc_state [TABLE_SIZE];
    int         rr_ptr;
    int         running_pid;
    bit         running_set;

    rsp_t       pending_outcomes [$];
    stim_row_t  directed_rows [$];
    int         mismatches;
    int         cycles;
    int         responses_seen;

    process_table_round_robin_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // A hung handshake or a block that stops answering ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Every mismatch goes through here: one line is printed and it is counted.
    task automatic note_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Applies one request to the predictor's table and returns the response that
    // the block must give for it.
    function automatic rsp_t run_table_op(input req_t r);
        rsp_t o;
        int   idx;
        int   pick;
        bit   hit;
        o    = '0;
        hit  = 1'b0;
        pick = 0;
        case (r.opcode)
            OP_CREATE:
            begin
                o.pid_out = r.pid;
                if (int'(r.pid) >= TABLE_SIZE)
                begin
                    o.status = RS_NOCHANGE;
                end
                else
                begin
                    // Create always wins, whatever the entry held before.
                    proc_state[r.pid] = PS_READY;
                    o.status    = RS_DONE;
                    o.state_out = PS_READY;
                end
            end
            OP_TERMINATE:
            begin
                o.pid_out = r.pid;
                if (int'(r.pid) >= TABLE_SIZE)
                begin
                    o.status = RS_NOCHANGE;
                end
                else if (proc_state[r.pid] == PS_TERMINATED)
                begin
                    o.status    = RS_NOCHANGE;
                    o.state_out = PS_TERMINATED;
                end
                else
                begin
                    proc_state[r.pid] = PS_TERMINATED;
                    o.status    = RS_DONE;
                    o.state_out = PS_TERMINATED;
                end
            end
            OP_SCHEDULE:
            begin
                // Search starts one past the last pick and wraps round the table
                // once, so the last pick itself is looked at last.
                idx = rr_ptr;
                for (int n = 0; n < TABLE_SIZE; n++)
                begin
                    idx = (idx + 1) % TABLE_SIZE;
                    if (!hit && proc_state[idx] == PS_READY)
                    begin
                        hit  = 1'b1;
                        pick = idx;
                    end
                end
                if (hit)
                begin
                    // The old runner drops back to ready only if nobody has
                    // terminated or re-created it since it was picked.
                    if (running_set && proc_state[running_pid] == PS_RUNNING)
                    begin
                        proc_state[running_pid] = PS_READY;
                    end
                    proc_state[pick] = PS_RUNNING;
                    rr_ptr      = pick;
                    running_pid = pick;
                    running_set = 1'b1;
                    o.status    = RS_DONE;
                    o.pid_out   = pick[PID_W-1:0];
                    o.state_out = PS_RUNNING;
                end
                else
                begin
                    o.status = RS_NONE;
                end
            end
            default:
            begin
                o.status = RS_NOCHANGE;
            end
        endcase
        return o;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [PID_W-1:0] pid,
                           input logic known, input logic [1:0] status,
                           input logic [PID_W-1:0] pid_out, input logic [2:0] st);
        stim_row_t row;
        row.opcode         = op;
        row.pid            = pid;
        row.known          = known;
        row.want.status    = status;
        row.want.pid_out   = pid_out;
        row.want.state_out = st;
        directed_rows.push_back(row);
    endtask

    // Offers one request after an idle gap and holds it until the block takes it.
    // The predictor only moves on once the request has really been accepted.
    task automatic offer(input req_t item, input logic known, input rsp_t want,
                         input int gap);
        rsp_t model_out;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        model_out = run_table_op(item);
        pending_outcomes.push_back(known ? want : model_out);
    endtask

    // Sender gaps: mostly none or short, now and then a long one.
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Response side: checks each accepted response against the oldest waiting
    // prediction and drives rsp_stall in bursts of free and stalled cycles.
    initial
    begin : response_side
        int   stall_left;
        int   free_left;
        bit   held_off;
        rsp_t want;
        stall_left = 0;
        free_left  = 0;
        held_off   = 1'b0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                responses_seen++;
                if (pending_outcomes.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected response %0d/%0d/%0d",
                                  rsp.status, rsp.pid_out, rsp.state_out));
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        note_mismatch($sformatf("status %0d, predicted %0d",
                                      rsp.status, want.status));
                    end
                    if (rsp.pid_out !== want.pid_out)
                    begin
                        note_mismatch($sformatf("pid_out %0d, predicted %0d",
                                      rsp.pid_out, want.pid_out));
                    end
                    if (rsp.state_out !== want.state_out)
                    begin
                        note_mismatch($sformatf("state_out %0d, predicted %0d",
                                      rsp.state_out, want.state_out));
                    end
                end
            end
            // Once, part way through the random requests, the receiver refuses
            // responses for a long stretch. The sender keeps offering, so the
            // response register fills and the block must stall its input.
            if (!held_off && responses_seen >= HOLD_OFF_AFTER)
            begin
                held_off   = 1'b1;
                stall_left = HOLD_OFF_CYCLES;
                free_left  = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                rsp_stall <= 1'b0;
            end
            else
            begin
                // A new burst: a stall that is usually short and only now and then long,
                // then a run of free cycles, sometimes long.
                free_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 6);
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                           : ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin : request_side
        req_t             item;
        rsp_t             no_want;
        logic [PID_W-1:0] pid_pool [8];
        int               roll;
        int               gap;

        cycles         = 0;
        mismatches     = 0;
        responses_seen = 0;
        no_want        = '0;
        rr_ptr         = 0;
        running_pid    = 0;
        running_set    = 1'b0;
        foreach (proc_state[i])
        begin
            proc_state[i] = PS_NEW;
        end
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        // Directed part. Rows with a typed response can be read off directly:
        // a fresh table, terminate twice, create over a terminated entry, the
        // table's end entries and the unused opcode. The rest go to the predictor.
        add_row(OP_SCHEDULE,  8'h00, 1'b1, RS_NONE,     8'h00, PS_NEW);
        add_row(OP_TERMINATE, 8'h00, 1'b1, RS_DONE,     8'h00, PS_TERMINATED);
        add_row(OP_TERMINATE, 8'h00, 1'b1, RS_NOCHANGE, 8'h00, PS_TERMINATED);
        add_row(OP_CREATE,    8'h00, 1'b1, RS_DONE,     8'h00, PS_READY);
        add_row(OP_CREATE,    8'hFF, 1'b1, RS_DONE,     8'hFF, PS_READY);
        add_row(OP_UNUSED,    8'hFF, 1'b1, RS_NOCHANGE, 8'h00, PS_NEW);
        // Three schedules walk round the wrap; each after the first demotes the runner.
        add_row(OP_SCHEDULE,  8'hFF, 1'b0, RS_DONE,     8'h00, PS_NEW);
        add_row(OP_SCHEDULE,  8'h5A, 1'b0, RS_DONE,     8'h00, PS_NEW);
        add_row(OP_SCHEDULE,  8'hA5, 1'b0, RS_DONE,     8'h00, PS_NEW);
        // Terminating the runner: the next pick must not revive it.
        add_row(OP_TERMINATE, 8'hFF, 1'b1, RS_DONE,     8'hFF, PS_TERMINATED);
        add_row(OP_SCHEDULE,  8'h00, 1'b0, RS_DONE,     8'h00, PS_NEW);
        // Re-creating the runner leaves it ready, so no demotion follows.
        add_row(OP_CREATE,    8'h00, 1'b1, RS_DONE,     8'h00, PS_READY);
        add_row(OP_CREATE,    8'h80, 1'b1, RS_DONE,     8'h80, PS_READY);
        add_row(OP_SCHEDULE,  8'h00, 1'b0, RS_DONE,     8'h00, PS_NEW);
        add_row(OP_SCHEDULE,  8'h00, 1'b0, RS_DONE,     8'h00, PS_NEW);
        add_row(OP_TERMINATE, 8'h00, 1'b1, RS_DONE,     8'h00, PS_TERMINATED);
        add_row(OP_TERMINATE, 8'h80, 1'b1, RS_DONE,     8'h80, PS_TERMINATED);
        add_row(OP_SCHEDULE,  8'h33, 1'b1, RS_NONE,     8'h00, PS_NEW);
        add_row(OP_CREATE,    8'hAA, 1'b1, RS_DONE,     8'hAA, PS_READY);
        add_row(OP_CREATE,    8'h55, 1'b1, RS_DONE,     8'h55, PS_READY);
        add_row(OP_UNUSED,    8'h00, 1'b1, RS_NOCHANGE, 8'h00, PS_NEW);
        add_row(OP_SCHEDULE,  8'h00, 1'b0, RS_DONE,     8'h00, PS_NEW);
        add_row(OP_SCHEDULE,  8'h00, 1'b0, RS_DONE,     8'h00, PS_NEW);
        add_row(OP_TERMINATE, 8'hAA, 1'b1, RS_DONE,     8'hAA, PS_TERMINATED);
        // The terminated runner is passed over and the demoted entry runs again.
        add_row(OP_SCHEDULE,  8'h00, 1'b0, RS_DONE,     8'h00, PS_NEW);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            item.opcode = directed_rows[i].opcode;
            item.pid    = directed_rows[i].pid;
            offer(item, directed_rows[i].known, directed_rows[i].want, sender_gap());
        end

        // Random part. Most requests address a small pool of entries, refreshed
        // every so often, so that the same processes are created, scheduled,
        // terminated and re-created again and again; a few go anywhere in the
        // table so that every pid bit toggles.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
            begin
                foreach (pid_pool[k])
                begin
                    pid_pool[k] = PID_W'($urandom_range(0, 255));
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                item.opcode = OP_CREATE;
            end
            else if (roll < 60)
            begin
                item.opcode = OP_TERMINATE;
            end
            else if (roll < 96)
            begin
                item.opcode = OP_SCHEDULE;
            end
            else
            begin
                item.opcode = OP_UNUSED;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                item.pid = pid_pool[$urandom_range(0, 7)];
            end
            else
            begin
                item.pid = PID_W'($urandom_range(0, 255));
            end
            // Every hundred requests begins with a back-to-back run.
            gap = (i % 100 < 25) ? 0 : sender_gap();
            offer(item, 1'b0, no_want, gap);
        end
        req_valid <= 1'b0;

        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        // A late or duplicated response would show up in this window.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
